FILE: hw/rtl/rre_pkg.sv
// Package for the RTT/RTO estimator: widths, reset values, command and
// register codes, configuration and estimator state structs.
// No dependencies.
`timescale 1ns / 1ps

package rre_pkg;

    localparam int TICK_W     = 16;
    localparam int SCALED_W   = 24;
    localparam int SHIFT_W    = 3;
    localparam int BO_EXP_W   = 3;
    localparam int BACKOFF_W  = 7;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    // scaled variance after the widest left shift (exponent plus srtt fraction)
    localparam int VAR_W      = SCALED_W + 14;

    localparam logic [SCALED_W-1:0] SCALED_MAX  = {SCALED_W{1'b1}};
    localparam logic [TICK_W-1:0]   TICK_MAX    = {TICK_W{1'b1}};
    localparam logic [TICK_W-1:0]   RTO_FLOOR   = TICK_W'(2);
    localparam logic [BO_EXP_W-1:0] BO_CAP_EXP  = BO_EXP_W'(6);
    localparam logic [BO_EXP_W-1:0] BO_FOLD_EXP = BO_EXP_W'(3);

    localparam logic [SHIFT_W-1:0]  RST_SRTT_SHIFT   = SHIFT_W'(3);
    localparam logic [SHIFT_W-1:0]  RST_RTTVAR_SHIFT = SHIFT_W'(2);
    localparam logic [SHIFT_W-1:0]  RST_VAR_EXP      = SHIFT_W'(2);
    localparam logic [TICK_W-1:0]   RST_MIN_RTO      = TICK_W'(2);
    localparam logic [TICK_W-1:0]   RST_MAX_RTO      = TICK_W'(640);
    localparam logic [TICK_W-1:0]   RST_INIT_RTTVAR  = TICK_W'(120);
    localparam logic [TICK_W-1:0]   RST_INIT_RTO     = TICK_W'(10);
    localparam logic [SCALED_W-1:0] RST_RTTVAR       = SCALED_W'(480);

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_BACKOFF = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRTT_SHIFT   = 3'd0,
        CFG_RTTVAR_SHIFT = 3'd1,
        CFG_VAR_EXP      = 3'd2,
        CFG_MIN_RTO      = 3'd3,
        CFG_MAX_RTO      = 3'd4,
        CFG_RFC_MODE     = 3'd5,
        CFG_INIT_RTTVAR  = 3'd6,
        CFG_INIT_RTO     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [SHIFT_W-1:0] srtt_shift;
        logic [SHIFT_W-1:0] rttvar_shift;
        logic [SHIFT_W-1:0] var_exp;
        logic [TICK_W-1:0]  min_rto;
        logic [TICK_W-1:0]  max_rto;
        logic               rfc_mode;
        logic [TICK_W-1:0]  init_rttvar;
        logic [TICK_W-1:0]  init_rto;
    } t_cfg;

    typedef struct packed {
        logic [SCALED_W-1:0] srtt;
        logic [SCALED_W-1:0] rttvar;
        logic [BO_EXP_W-1:0] bo_exp;
    } t_est;

endpackage

FILE: hw/rtl/rre_state.sv
// Estimator state stage: scaled srtt, scaled rttvar and backoff exponent,
// updated once per command. Depends on rre_pkg.
`timescale 1ns / 1ps

module rre_state import rre_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_upd,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [TICK_W-1:0] i_rtt,
    output t_est              o_est
);

    t_est                r_est;
    t_est                n_est;
    logic [TICK_W-1:0]   rtt;
    logic [SCALED_W-1:0] srtt_unsc;
    logic [SCALED_W:0]   srtt_sum;
    logic [SCALED_W-1:0] mag;
    logic [SCALED_W+1:0] var_sum;
    logic [SCALED_W-1:0] srtt_sm;
    logic [SCALED_W-1:0] var_sm;
    logic [SCALED_W-1:0] seed_srtt;
    logic [SCALED_W-1:0] seed_var;
    logic [SCALED_W:0]   fold_sum;
    logic [BO_EXP_W-1:0] bo_next;

    always_comb begin
        rtt       = (i_rtt == '0) ? TICK_W'(1) : i_rtt;
        srtt_unsc = r_est.srtt >> i_cfg.srtt_shift;
        srtt_sum  = {1'b0, r_est.srtt} + (SCALED_W+1)'(rtt) - {1'b0, srtt_unsc};
        srtt_sm   = (srtt_sum > (SCALED_W+1)'(SCALED_MAX)) ? SCALED_MAX
                                                           : srtt_sum[SCALED_W-1:0];
        if (SCALED_W'(rtt) >= srtt_unsc) begin
            mag = SCALED_W'(rtt) - srtt_unsc;
        end else begin
            mag = srtt_unsc - SCALED_W'(rtt);
        end
        var_sum = (SCALED_W+2)'(r_est.rttvar) + (SCALED_W+2)'(mag)
                - (SCALED_W+2)'(r_est.rttvar >> i_cfg.rttvar_shift);
        if (var_sum == '0) begin
            var_sm = SCALED_W'(1);
        end else if (var_sum > (SCALED_W+2)'(SCALED_MAX)) begin
            var_sm = SCALED_MAX;
        end else begin
            var_sm = var_sum[SCALED_W-1:0];
        end
        seed_srtt = SCALED_W'(rtt) << i_cfg.srtt_shift;
        if (i_cfg.rttvar_shift == '0) begin
            seed_var = SCALED_W'(rtt >> 1);
        end else begin
            seed_var = SCALED_W'(rtt) << (i_cfg.rttvar_shift - SHIFT_W'(1));
        end
        fold_sum = {1'b0, r_est.rttvar} + {1'b0, srtt_unsc};
        bo_next  = (r_est.bo_exp < BO_CAP_EXP) ? r_est.bo_exp + BO_EXP_W'(1)
                                               : r_est.bo_exp;

        n_est = r_est;
        case (t_cmd'(i_cmd))
            CMD_SAMPLE: begin
                if (r_est.srtt != '0) begin
                    n_est.srtt   = srtt_sm;
                    n_est.rttvar = var_sm;
                end else begin
                    n_est.srtt   = seed_srtt;
                    n_est.rttvar = seed_var;
                end
            end
            CMD_BACKOFF: begin
                n_est.bo_exp = bo_next;
                if (bo_next > BO_FOLD_EXP) begin
                    n_est.rttvar = fold_sum[SCALED_W] ? SCALED_MAX
                                                      : fold_sum[SCALED_W-1:0];
                    n_est.srtt   = '0;
                end
            end
            CMD_RESTART: begin
                n_est.srtt   = '0;
                n_est.rttvar = SCALED_W'(i_cfg.init_rttvar) << i_cfg.rttvar_shift;
                n_est.bo_exp = '0;
            end
            default: begin
                n_est = r_est;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est.srtt   <= '0;
            r_est.rttvar <= RST_RTTVAR;
            r_est.bo_exp <= '0;
        end else if (i_upd) begin
            r_est <= n_est;
        end
    end

    assign o_est = r_est;

endmodule

FILE: hw/rtl/rre_rto_out.sv
// Timeout stage: current RTO register, timeout clamp and result register.
// Depends on rre_pkg.
`timescale 1ns / 1ps

module rre_rto_out import rre_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_load,
    input  logic [CMD_W-1:0]     i_cmd,
    input  t_est                 i_est,
    output logic [TICK_W-1:0]    o_rto_ticks,
    output logic [TICK_W-1:0]    o_srtt_ticks,
    output logic [BACKOFF_W-1:0] o_backoff_factor
);

    logic [TICK_W-1:0]    r_cur_rto;
    logic [TICK_W-1:0]    n_cur_rto;
    logic [TICK_W-1:0]    r_rto;
    logic [TICK_W-1:0]    r_srtt_ticks;
    logic [BACKOFF_W-1:0] r_backoff;
    logic [3:0]           lsh;
    logic [3:0]           rsh;
    logic [VAR_W-1:0]     var_sh;
    logic [VAR_W:0]       tot;
    logic [VAR_W:0]       tot_unsc;
    logic [TICK_W-1:0]    calc_rto;
    logic [TICK_W-1:0]    base;
    logic [TICK_W+5:0]    prod;
    logic [TICK_W-1:0]    n_rto;
    logic [SCALED_W-1:0]  srtt_unsc;
    logic [TICK_W-1:0]    n_srtt_ticks;

    always_comb begin
        lsh = 4'(i_cfg.var_exp) + 4'(i_cfg.srtt_shift);
        rsh = 4'(i_cfg.rttvar_shift);
        if (lsh >= rsh) begin
            var_sh = VAR_W'(i_est.rttvar) << (lsh - rsh);
        end else begin
            var_sh = VAR_W'(i_est.rttvar) >> (rsh - lsh);
        end
        tot      = (VAR_W+1)'(var_sh) + (VAR_W+1)'(i_est.srtt);
        tot_unsc = tot >> i_cfg.srtt_shift;
        calc_rto = (|tot_unsc[VAR_W:TICK_W]) ? TICK_MAX : tot_unsc[TICK_W-1:0];

        case (t_cmd'(i_cmd))
            CMD_SAMPLE:  n_cur_rto = calc_rto;
            CMD_RESTART: n_cur_rto = i_cfg.init_rto;
            default:     n_cur_rto = r_cur_rto;
        endcase

        base = (i_cfg.rfc_mode && n_cur_rto < i_cfg.min_rto) ? i_cfg.min_rto : n_cur_rto;
        prod = (TICK_W+6)'(base) << i_est.bo_exp;
        if (!i_cfg.rfc_mode && prod < (TICK_W+6)'(i_cfg.min_rto)) begin
            prod = (TICK_W+6)'(i_cfg.min_rto);
        end
        if (prod > (TICK_W+6)'(i_cfg.max_rto)) begin
            prod = (TICK_W+6)'(i_cfg.max_rto);
        end
        if (prod < (TICK_W+6)'(RTO_FLOOR)) begin
            prod = (TICK_W+6)'(RTO_FLOOR);
        end
        n_rto = prod[TICK_W-1:0];

        srtt_unsc    = i_est.srtt >> i_cfg.srtt_shift;
        n_srtt_ticks = (|srtt_unsc[SCALED_W-1:TICK_W]) ? TICK_MAX
                                                       : srtt_unsc[TICK_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_rto <= RST_INIT_RTO;
        end else if (i_load) begin
            r_cur_rto <= n_cur_rto;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rto        <= n_rto;
            r_srtt_ticks <= n_srtt_ticks;
            r_backoff    <= BACKOFF_W'(1) << i_est.bo_exp;
        end
    end

    assign o_rto_ticks      = r_rto;
    assign o_srtt_ticks     = r_srtt_ticks;
    assign o_backoff_factor = r_backoff;

endmodule

FILE: hw/rtl/rtt_rto_estimator_unit.sv
// RTT/RTO estimator top level: configuration registers, input register,
// three-stage valid/stall pipeline. Depends on rre_pkg, rre_state, rre_rto_out.
// Each item passes the input, state and result registers in turn.
// Throughput: one item per cycle; stalls only when all three stages hold items.
// Reset (synchronous, active low) loads default configuration and initial state.
`timescale 1ns / 1ps

module rtt_rto_estimator_unit import rre_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [TICK_W-1:0]     i_rtt_sample_ticks,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [TICK_W-1:0]     o_rto_ticks,
    output logic [TICK_W-1:0]     o_srtt_ticks,
    output logic [BACKOFF_W-1:0]  o_backoff_factor
);

    t_cfg              r_cfg;
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic [CMD_W-1:0]  r_in_cmd;
    logic [TICK_W-1:0] r_in_rtt;
    logic [CMD_W-1:0]  r_s2_cmd;
    logic              ld3;
    logic              s2_free;
    logic              s1_free;
    logic              s2_load;
    logic              s3_load;
    logic              in_xfer;
    t_est              w_est;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.srtt_shift   <= RST_SRTT_SHIFT;
            r_cfg.rttvar_shift <= RST_RTTVAR_SHIFT;
            r_cfg.var_exp      <= RST_VAR_EXP;
            r_cfg.min_rto      <= RST_MIN_RTO;
            r_cfg.max_rto      <= RST_MAX_RTO;
            r_cfg.rfc_mode     <= 1'b1;
            r_cfg.init_rttvar  <= RST_INIT_RTTVAR;
            r_cfg.init_rto     <= RST_INIT_RTO;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SRTT_SHIFT:   r_cfg.srtt_shift   <= i_cfg_data[SHIFT_W-1:0];
                CFG_RTTVAR_SHIFT: r_cfg.rttvar_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_VAR_EXP:      r_cfg.var_exp      <= i_cfg_data[SHIFT_W-1:0];
                CFG_MIN_RTO:      r_cfg.min_rto      <= i_cfg_data[TICK_W-1:0];
                CFG_MAX_RTO:      r_cfg.max_rto      <= i_cfg_data[TICK_W-1:0];
                CFG_RFC_MODE:     r_cfg.rfc_mode     <= i_cfg_data[0];
                CFG_INIT_RTTVAR:  r_cfg.init_rttvar  <= i_cfg_data[TICK_W-1:0];
                CFG_INIT_RTO:     r_cfg.init_rto     <= i_cfg_data[TICK_W-1:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // each stage fills whenever it is empty or its item moves on
    assign ld3     = !r_v3 || !i_stall;
    assign s3_load = r_v2 && ld3;
    assign s2_free = !r_v2 || ld3;
    assign s2_load = r_v1 && s2_free;
    assign s1_free = !r_v1 || s2_free;
    assign in_xfer = i_valid && s1_free;
    assign o_stall = !s1_free;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s1_free) begin
                r_v1 <= i_valid;
            end
            if (s2_free) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_cmd <= i_command;
            r_in_rtt <= i_rtt_sample_ticks;
        end
        if (s2_load) begin
            r_s2_cmd <= r_in_cmd;
        end
    end

    rre_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_upd   (s2_load),
        .i_cmd   (r_in_cmd),
        .i_rtt   (r_in_rtt),
        .o_est   (w_est)
    );

    rre_rto_out u_rto_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_load           (s3_load),
        .i_cmd            (r_s2_cmd),
        .i_est            (w_est),
        .o_rto_ticks      (o_rto_ticks),
        .o_srtt_ticks     (o_srtt_ticks),
        .o_backoff_factor (o_backoff_factor)
    );

`ifndef SYNTHESIS
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with a free pipeline stage");

    a_backoff_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($onehot(o_backoff_factor) && o_backoff_factor <= BACKOFF_W'(64)))
        else $error("backoff factor not a power of two up to 64");

    a_rto_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rto_ticks >= RTO_FLOOR))
        else $error("timeout below floor");

    a_sample_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_load && r_in_cmd == CMD_SAMPLE) |=> (w_est.srtt != '0))
        else $error("smoothed round trip zero after a sample");
`endif

endmodule
